>>> src/mcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared constants, types and the quarter-wave sine builder for the
// metronome click synthesizer.
// ----------------------------------------------------------------------------
package mcs_pkg;

  localparam int PHASE_BITS_DEF      = 16;
  localparam int SINE_TABLE_BITS_DEF = 10;

  localparam int BEAT_W   = 32;
  localparam int BEAT_CNT_W = $clog2(BEAT_W);
  localparam int SAMPLE_W = 16;
  localparam int ENV_W    = 16;
  localparam int STEP_W   = 16;
  localparam int BPB_W    = 7;
  localparam int MAG_W    = 15;
  localparam int MUL_A_W  = 31;
  localparam int MUL_B_W  = 16;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] REG_ENABLE        = 2'd0;
  localparam logic [1:0] REG_BAR_LEN       = 2'd1;
  localparam logic [1:0] REG_DOWNBEAT_STEP = 2'd2;
  localparam logic [1:0] REG_BEAT_STEP     = 2'd3;

  localparam logic              ENABLE_RST        = 1'b1;
  localparam logic [BPB_W-1:0]  BAR_LEN_RST       = 7'd4;
  localparam logic [STEP_W-1:0] DOWNBEAT_STEP_RST = 16'd1911;
  localparam logic [STEP_W-1:0] BEAT_STEP_RST     = 16'd1365;
  localparam logic [BPB_W-1:0]  BEATS_DEFAULT     = 7'd4;

  localparam logic [ENV_W-1:0]   ENV_ONE       = 16'd32768;
  localparam logic [ENV_W-1:0]   SILENCE_LEVEL = 16'd16;
  localparam logic [MUL_B_W-1:0] DECAY_Q15     = 16'd32604;
  localparam logic [MUL_B_W-1:0] GAIN_Q15      = 16'd6554;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [9:0]  TAYLOR_DEN [11] =
    '{10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156, 10'd210, 10'd272,
      10'd342, 10'd420, 10'd506};

  typedef struct packed {
    logic              enable;
    logic [BPB_W-1:0]  bar_len;
    logic [STEP_W-1:0] downbeat_step;
    logic [STEP_W-1:0] beat_step;
  } cfg_t;

  typedef enum logic [1:0] {
    MUL_SIN_ENV,
    MUL_GAIN,
    MUL_DECAY
  } mul_sel_t;

  typedef struct packed {
    logic     trig_load;
    logic     mod_step;
    logic     flag_load;
    logic     phase_adv;
    logic     rom_read;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     res_clear;
    logic     res_load;
    logic     env_load;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic silent;
  } dp_stat_t;

  // round(32767 * sin(k / quarter * pi/2)), quarter = 2^(tb-2)
  function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k,
                                                    input int unsigned tb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x    = (HALF_PI_Q30 * 64'(k)) >> (tb - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n < 12; n++) begin
      term = (term * x2) >> 30;
      term = term / 64'(TAYLOR_DEN[n-1]);
      if (n[0]) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    v = (sum * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> src/mcs_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcs_regs
// APB register file: enable, beats per bar and the two phase steps.
// ----------------------------------------------------------------------------
module mcs_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mcs_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mcs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mcs_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output mcs_pkg::cfg_t                      cfg
);

  logic       wr;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable        <= mcs_pkg::ENABLE_RST;
      cfg.bar_len       <= mcs_pkg::BAR_LEN_RST;
      cfg.downbeat_step <= mcs_pkg::DOWNBEAT_STEP_RST;
      cfg.beat_step     <= mcs_pkg::BEAT_STEP_RST;
    end else if (wr) begin
      case (reg_idx)
        mcs_pkg::REG_ENABLE:        cfg.enable        <= pwdata[0];
        mcs_pkg::REG_BAR_LEN:       cfg.bar_len       <= pwdata[mcs_pkg::BPB_W-1:0];
        mcs_pkg::REG_DOWNBEAT_STEP: cfg.downbeat_step <= pwdata[mcs_pkg::STEP_W-1:0];
        mcs_pkg::REG_BEAT_STEP:     cfg.beat_step     <= pwdata[mcs_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mcs_pkg::REG_ENABLE:        prdata = mcs_pkg::APB_DATA_W'(cfg.enable);
      mcs_pkg::REG_BAR_LEN:       prdata = mcs_pkg::APB_DATA_W'(cfg.bar_len);
      mcs_pkg::REG_DOWNBEAT_STEP: prdata = mcs_pkg::APB_DATA_W'(cfg.downbeat_step);
      mcs_pkg::REG_BEAT_STEP:     prdata = mcs_pkg::APB_DATA_W'(cfg.beat_step);
      default:                    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> src/mcs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcs_ctrl
// Sequencer: bar-position division for triggers, table read, three
// multiplies and output register handoff for sample requests.
// ----------------------------------------------------------------------------
module mcs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cmd,
  output logic                out_valid,
  input  logic                out_stall,
  input  mcs_pkg::dp_stat_t   stat,
  output mcs_pkg::dp_cmd_t    dp_cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_FLAG,
    S_ROM,
    S_MUL_ENV,
    S_MUL_GAIN,
    S_DECAY,
    S_ENV,
    S_FIN
  } state_t;

  state_t                         state;
  logic [mcs_pkg::BEAT_CNT_W-1:0] cnt;
  logic                           accept;
  logic                           out_free;

  assign in_stall = rst || (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    dp_cmd           = '0;
    dp_cmd.mul_sel   = mcs_pkg::MUL_SIN_ENV;
    case (state)
      S_IDLE: begin
        if (accept) begin
          dp_cmd.trig_load = cmd;
          dp_cmd.res_clear = !cmd && stat.silent;
          dp_cmd.phase_adv = !cmd && !stat.silent;
        end
      end
      S_MOD:  dp_cmd.mod_step  = 1'b1;
      S_FLAG: dp_cmd.flag_load = 1'b1;
      S_ROM:  dp_cmd.rom_read  = 1'b1;
      S_MUL_ENV: begin
        dp_cmd.mul_en  = 1'b1;
        dp_cmd.mul_sel = mcs_pkg::MUL_SIN_ENV;
      end
      S_MUL_GAIN: begin
        dp_cmd.mul_en  = 1'b1;
        dp_cmd.mul_sel = mcs_pkg::MUL_GAIN;
      end
      S_DECAY: begin
        dp_cmd.mul_en   = 1'b1;
        dp_cmd.mul_sel  = mcs_pkg::MUL_DECAY;
        dp_cmd.res_load = 1'b1;
      end
      S_ENV:  dp_cmd.env_load = 1'b1;
      S_FIN:  dp_cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cnt <= '0;
            if (cmd) begin
              state <= S_MOD;
            end else if (stat.silent) begin
              state <= S_FIN;
            end else begin
              state <= S_ROM;
            end
          end
        end
        S_MOD: begin
          cnt <= cnt + mcs_pkg::BEAT_CNT_W'(1);
          if (cnt == '1) begin
            state <= S_FLAG;
          end
        end
        S_FLAG:     state <= S_IDLE;
        S_ROM:      state <= S_MUL_ENV;
        S_MUL_ENV:  state <= S_MUL_GAIN;
        S_MUL_GAIN: state <= S_DECAY;
        S_DECAY:    state <= S_ENV;
        S_ENV:      state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/mcs_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcs_datapath
// Click state, bit-serial bar-position divider, phase accumulator,
// quarter-wave sine table, shared multiplier and output register.
// ----------------------------------------------------------------------------
module mcs_datapath #(
  parameter int PHASE_BITS      = mcs_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = mcs_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mcs_pkg::cfg_t                       cfg,
  input  mcs_pkg::dp_cmd_t                    dp_cmd,
  output mcs_pkg::dp_stat_t                   stat,
  input  logic [mcs_pkg::BEAT_W-1:0]          beat_num,
  output logic signed [mcs_pkg::SAMPLE_W-1:0] sample,
  output logic                                is_downbeat
);

  localparam int TB      = SINE_TABLE_BITS;
  localparam int KW      = TB - 1;
  localparam int QUARTER = 1 << (TB - 2);

  typedef logic [mcs_pkg::MAG_W-1:0] qtab_t [QUARTER+1];

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int i = 0; i <= QUARTER; i++) begin
      t[i] = mcs_pkg::quarter_sine(int'(i), int'(TB));
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  logic [PHASE_BITS-1:0]             phase;
  logic [mcs_pkg::ENV_W-1:0]         env;
  logic                              flag;
  logic [mcs_pkg::BEAT_W-1:0]        dividend;
  logic [mcs_pkg::BPB_W-1:0]         rem;
  logic                              neg;
  logic [KW-1:0]                     k;
  logic [mcs_pkg::MAG_W-1:0]         s_mag;
  logic [mcs_pkg::PROD_W-1:0]        prod;
  logic [mcs_pkg::SAMPLE_W-1:0]      res;

  logic [mcs_pkg::STEP_W-1:0]        step;
  logic [PHASE_BITS-1:0]             phase_next;
  logic [TB-1:0]                     idx;
  logic [KW-1:0]                     k_next;
  logic [mcs_pkg::BEAT_W-1:0]        beat_abs;
  logic [mcs_pkg::BPB_W-1:0]         divisor;
  logic [mcs_pkg::BPB_W:0]           trial;
  logic [mcs_pkg::BPB_W:0]           trial_diff;
  logic [mcs_pkg::MUL_A_W-1:0]       mul_a;
  logic [mcs_pkg::MUL_B_W-1:0]       mul_b;
  logic [mcs_pkg::PROD_W-1:0]        mul_p;
  logic [44:0]                       rounded;
  logic [mcs_pkg::MAG_W-1:0]         mag;

  assign stat.silent = !cfg.enable || (env <= mcs_pkg::SILENCE_LEVEL);

  assign step       = flag ? cfg.downbeat_step : cfg.beat_step;
  assign phase_next = phase + PHASE_BITS'(step);

  generate
    if (PHASE_BITS >= TB) begin : g_idx_hi
      assign idx = phase_next[PHASE_BITS-1 -: TB];
    end else begin : g_idx_lo
      assign idx = {phase_next, {(TB-PHASE_BITS){1'b0}}};
    end
  endgenerate

  assign k_next = idx[TB-2] ? (KW'(QUARTER) - {1'b0, idx[TB-3:0]})
                            : {1'b0, idx[TB-3:0]};

  assign beat_abs = beat_num[mcs_pkg::BEAT_W-1] ? (~beat_num + mcs_pkg::BEAT_W'(1))
                                                : beat_num;

  assign divisor    = (cfg.bar_len == '0) ? mcs_pkg::BEATS_DEFAULT
                                          : cfg.bar_len;
  assign trial      = {rem, dividend[mcs_pkg::BEAT_W-1]};
  assign trial_diff = trial - {1'b0, divisor};

  always_comb begin
    case (dp_cmd.mul_sel)
      mcs_pkg::MUL_SIN_ENV: begin
        mul_a = mcs_pkg::MUL_A_W'(s_mag);
        mul_b = env;
      end
      mcs_pkg::MUL_GAIN: begin
        mul_a = prod[mcs_pkg::MUL_A_W-1:0];
        mul_b = mcs_pkg::GAIN_Q15;
      end
      mcs_pkg::MUL_DECAY: begin
        mul_a = mcs_pkg::MUL_A_W'(env);
        mul_b = mcs_pkg::DECAY_Q15;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mcs_pkg::PROD_W'(mul_a) * mcs_pkg::PROD_W'(mul_b);
  assign rounded = 45'(prod[43:0]) + (45'd1 << 29);
  assign mag     = rounded[44:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      env   <= '0;
      flag  <= 1'b1;
    end else begin
      if (dp_cmd.trig_load) begin
        phase <= '0;
        env   <= mcs_pkg::ENV_ONE;
      end else if (dp_cmd.phase_adv) begin
        phase <= phase_next;
      end else if (dp_cmd.env_load) begin
        env <= prod[30:15];
      end
      if (dp_cmd.flag_load) begin
        flag <= (rem == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.trig_load) begin
      dividend <= beat_abs;
      rem      <= '0;
    end else if (dp_cmd.mod_step) begin
      dividend <= {dividend[mcs_pkg::BEAT_W-2:0], 1'b0};
      rem      <= trial_diff[mcs_pkg::BPB_W] ? trial[mcs_pkg::BPB_W-1:0]
                                             : trial_diff[mcs_pkg::BPB_W-1:0];
    end
    if (dp_cmd.phase_adv) begin
      k   <= k_next;
      neg <= idx[TB-1];
    end
    if (dp_cmd.rom_read) begin
      s_mag <= QTAB[k];
    end
    if (dp_cmd.mul_en) begin
      prod <= mul_p;
    end
    if (dp_cmd.res_clear) begin
      res <= '0;
    end else if (dp_cmd.res_load) begin
      res <= neg ? (~{1'b0, mag} + mcs_pkg::SAMPLE_W'(1)) : {1'b0, mag};
    end
    if (dp_cmd.out_load) begin
      sample      <= res;
      is_downbeat <= flag;
    end
  end

endmodule
`default_nettype wire

>>> src/metronome_click_synth_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// metronome_click_synth_core
// Decaying sine click generator for a metronome.
//
// Input channel (in_valid / in_stall): cmd = 1 triggers a click; the beat is
// a downbeat when beat_num is a multiple of bar_len (0 means 4).
// cmd = 0 requests one signed Q1.15 audio sample.
// Output channel (out_valid / out_stall): one transfer per sample request,
// none per trigger; is_downbeat tags the current click.
// One item is worked on at a time. A trigger runs the one-bit-per-cycle
// divider for the bar position; a sample request runs the table read,
// three passes through the shared multiplier and the output handoff, or
// only the handoff when the click is silent or disabled. The output
// register holds a finished sample while the receiver stalls; the next item
// is taken meanwhile, and a new sample waits for it to drain. Configuration
// goes through the APB port, written by the user only while the block is
// idle (not enforced by the block). Reset restores the register defaults,
// clears envelope and phase, sets the downbeat flag, holds in_stall high.
// ----------------------------------------------------------------------------
module metronome_click_synth_core #(
  parameter int PHASE_BITS      = mcs_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = mcs_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mcs_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [mcs_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [mcs_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                cmd,
  input  logic signed [mcs_pkg::BEAT_W-1:0]   beat_num,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mcs_pkg::SAMPLE_W-1:0] sample,
  output logic                                is_downbeat
);

  mcs_pkg::cfg_t     cfg;
  mcs_pkg::dp_cmd_t  dp_cmd;
  mcs_pkg::dp_stat_t stat;

  mcs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .dp_cmd    (dp_cmd)
  );

  mcs_datapath #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .dp_cmd      (dp_cmd),
    .stat        (stat),
    .beat_num    (beat_num),
    .sample      (sample),
    .is_downbeat (is_downbeat)
  );

endmodule
`default_nettype wire

>>> dv/click_tb_pkg.sv
// ----------------------------------------------------------------------------
// click_tb_pkg
// Item command codes shared by the click synthesizer stimulus and checker.
// ----------------------------------------------------------------------------
package click_tb_pkg;

  typedef enum logic {
    CMD_SAMPLE  = 1'b0,
    CMD_TRIGGER = 1'b1
  } click_cmd_t;

endpackage

>>> dv/click_scoreboard.sv
// ----------------------------------------------------------------------------
// click_scoreboard
// Watches the register port and both item channels of the click synthesizer.
// Tracks the register file and the click state (envelope, phase, downbeat
// flag) on its own, works out the sample owed for every accepted sample
// request and compares each output transfer against the oldest one owed.
// ----------------------------------------------------------------------------
module click_scoreboard (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [mcs_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [mcs_pkg::APB_DATA_W-1:0]      pwdata,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                cmd,
  input  logic signed [mcs_pkg::BEAT_W-1:0]   beat_num,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [mcs_pkg::SAMPLE_W-1:0] sample,
  input  logic                                is_downbeat,
  output int                                  errors,
  output int                                  pending,
  output int                                  compared,
  output int                                  audible
);

  localparam int TAB_BITS   = mcs_pkg::SINE_TABLE_BITS_DEF;
  localparam int PH_BITS    = mcs_pkg::PHASE_BITS_DEF;
  localparam int TAB_SIZE   = 1 << TAB_BITS;
  localparam int TAB_QUART  = TAB_SIZE / 4;
  localparam int SAMPLE_W   = mcs_pkg::SAMPLE_W;

  localparam longint unsigned PI_HALF_FX = 64'd1686629713;
  localparam longint unsigned UNIT_FX    = 64'd1 << 30;
  localparam logic [15:0]     ENV_FULL   = 16'd32768;
  localparam logic [15:0]     QUIET_MAX  = 16'd16;
  localparam logic [31:0]     DECAY_MUL  = 32'd32604;
  localparam longint unsigned GAIN_MUL   = 64'd6554;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       db;
  } click_out_t;

  click_out_t expected_q[$];
  int         sine_tab[TAB_SIZE];

  logic                          en_r;
  logic [mcs_pkg::BPB_W-1:0]     bpb_r;
  logic [mcs_pkg::STEP_W-1:0]    db_step_r;
  logic [mcs_pkg::STEP_W-1:0]    bt_step_r;
  logic [mcs_pkg::ENV_W-1:0]     env_r;
  logic [PH_BITS-1:0]            phase_r;
  logic                          flag_r;
  int                            err_n;
  int                            cmp_n;
  int                            aud_n;

  function automatic int taylor_sine(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned v;
    x    = (PI_HALF_FX * longint'(k)) / longint'(TAB_QUART);
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    for (int n = 1; n < 12; n++) begin
      term = (term * x2) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = (acc >= term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
    end
    if (acc > UNIT_FX) begin
      acc = UNIT_FX;
    end
    v = (acc * 64'd32767 + (UNIT_FX >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return int'(v);
  endfunction

  initial begin
    int quad;
    int r;
    int s;
    for (int i = 0; i < TAB_SIZE; i++) begin
      quad = i / TAB_QUART;
      r    = i % TAB_QUART;
      s    = (quad % 2 == 1) ? taylor_sine(TAB_QUART - r) : taylor_sine(r);
      sine_tab[i] = (quad >= 2) ? -s : s;
    end
  end

  task automatic advance_click(input logic c, input logic signed [mcs_pkg::BEAT_W-1:0] b);
    longint                       bars;
    longint                       pos;
    logic [TAB_BITS-1:0]          idx;
    int                           s;
    longint unsigned              mag;
    click_out_t                   e;
    if (c == click_tb_pkg::CMD_TRIGGER) begin
      if (bpb_r == '0) begin
        bars = 4;
      end else begin
        bars = longint'(bpb_r);
      end
      pos = longint'(b) % bars;
      if (pos < 0) begin
        pos = pos + bars;
      end
      env_r   = ENV_FULL;
      phase_r = '0;
      flag_r  = (pos == 0);
    end else begin
      e.db = flag_r;
      if (!en_r || env_r <= QUIET_MAX) begin
        e.smp = '0;
      end else begin
        phase_r = phase_r + (flag_r ? db_step_r : bt_step_r);
        idx     = phase_r[PH_BITS-1 -: TAB_BITS];
        s       = sine_tab[idx];
        mag     = longint'((s < 0) ? -s : s);
        mag     = (mag * longint'(env_r) * GAIN_MUL + (64'd1 << 29)) >> 30;
        if (mag > 64'd32767) begin
          mag = 64'd32767;
        end
        e.smp = mag[SAMPLE_W-1:0];
        if (s < 0) begin
          e.smp = -e.smp;
        end
        env_r = 16'((32'(env_r) * DECAY_MUL) >> 15);
      end
      expected_q.push_back(e);
    end
  endtask

  always @(posedge clk) begin : watch
    click_out_t got;
    if (rst) begin
      en_r      = mcs_pkg::ENABLE_RST;
      bpb_r     = mcs_pkg::BAR_LEN_RST;
      db_step_r = mcs_pkg::DOWNBEAT_STEP_RST;
      bt_step_r = mcs_pkg::BEAT_STEP_RST;
      env_r     = '0;
      phase_r   = '0;
      flag_r    = 1'b1;
      err_n     = 0;
      cmp_n     = 0;
      aud_n     = 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[mcs_pkg::APB_ADDR_W-1:2])
          mcs_pkg::REG_ENABLE:        en_r      = pwdata[0];
          mcs_pkg::REG_BAR_LEN:       bpb_r     = pwdata[mcs_pkg::BPB_W-1:0];
          mcs_pkg::REG_DOWNBEAT_STEP: db_step_r = pwdata[mcs_pkg::STEP_W-1:0];
          mcs_pkg::REG_BEAT_STEP:     bt_step_r = pwdata[mcs_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected output transfer: sample %0d is_downbeat %0b",
                 sample, is_downbeat);
          err_n++;
        end else begin
          got = expected_q.pop_front();
          cmp_n++;
          if (got.smp != 0) begin
            aud_n++;
          end
          if (sample !== got.smp) begin
            $error("sample: expected %0d, actual %0d", got.smp, sample);
            err_n++;
          end
          if (is_downbeat !== got.db) begin
            $error("is_downbeat: expected %0b, actual %0b", got.db, is_downbeat);
            err_n++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        advance_click(cmd, beat_num);
      end
    end
    errors   <= err_n;
    pending  <= expected_q.size();
    compared <= cmp_n;
    audible  <= aud_n;
  end

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the metronome click synthesizer. Drives directed
// clicks (bar positions at the beat number extremes, disabled output, zero and
// full-scale steps, zero beats per bar) and then random click trains under
// several register settings. The sender works in bursts and the receiver
// stalls in shifting patterns; click_scoreboard does the checking.
// ----------------------------------------------------------------------------
module tb;

  typedef enum {
    STALL_NONE,
    STALL_COIN,
    STALL_COMB,
    STALL_LONG
  } stall_style_t;

  localparam int SETTLE_CYCLES = 48;

  logic                                clk         = 1'b0;
  logic                                rst         = 1'b1;
  logic                                psel        = 1'b0;
  logic                                penable     = 1'b0;
  logic                                pwrite      = 1'b0;
  logic [mcs_pkg::APB_ADDR_W-1:0]      paddr       = '0;
  logic [mcs_pkg::APB_DATA_W-1:0]      pwdata      = '0;
  logic [mcs_pkg::APB_DATA_W-1:0]      prdata;
  logic                                pready;
  logic                                in_valid    = 1'b0;
  logic                                in_stall;
  logic                                cmd         = click_tb_pkg::CMD_SAMPLE;
  logic signed [mcs_pkg::BEAT_W-1:0]   beat_num    = '0;
  logic                                out_valid;
  logic                                out_stall   = 1'b0;
  logic signed [mcs_pkg::SAMPLE_W-1:0] sample;
  logic                                is_downbeat;

  int errors;
  int pending;
  int compared;
  int audible;

  int           burst_left  = 0;
  int           n_triggers  = 0;
  int           n_requests  = 0;
  int           n_settings  = 0;
  int           cur_bars    = 4;
  stall_style_t stall_style = STALL_NONE;
  int           style_left  = 0;
  int           hold_left   = 0;
  logic         hold_val    = 1'b0;

  always #2 clk = ~clk;

  metronome_click_synth_core DUT (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .beat_num    (beat_num),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample      (sample),
    .is_downbeat (is_downbeat)
  );

  click_scoreboard u_scoreboard (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .beat_num    (beat_num),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample      (sample),
    .is_downbeat (is_downbeat),
    .errors      (errors),
    .pending     (pending),
    .compared    (compared),
    .audible     (audible)
  );

  always @(negedge clk) begin
    if (style_left == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      style_left  = $urandom_range(20, 300);
    end else begin
      style_left--;
    end
    case (stall_style)
      STALL_NONE: out_stall <= 1'b0;
      STALL_COIN: out_stall <= ($urandom_range(0, 1) == 1);
      STALL_COMB: out_stall <= (style_left % 5 < 2);
      default: begin
        if (hold_left == 0) begin
          hold_val  = ~hold_val;
          hold_left = $urandom_range(1, 30);
        end
        hold_left--;
        out_stall <= hold_val;
      end
    endcase
  end

  task automatic send_item(input click_tb_pkg::click_cmd_t c,
                           input logic signed [mcs_pkg::BEAT_W-1:0] b);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    cmd      <= c;
    beat_num <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (c == click_tb_pkg::CMD_TRIGGER) begin
      n_triggers++;
    end else begin
      n_requests++;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 12);
      gap = $urandom_range(1, 40);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // junk above each register's width must be dropped
  task automatic load_settings(input logic en, input int bars, input int dstep, input int bstep);
    reg_write(mcs_pkg::REG_ENABLE,        {$urandom_range(0, 1) == 1 ? 31'($urandom) : 31'd0, en});
    reg_write(mcs_pkg::REG_BAR_LEN,       {25'($urandom), 7'(bars)});
    reg_write(mcs_pkg::REG_DOWNBEAT_STEP, {16'($urandom), 16'(dstep)});
    reg_write(mcs_pkg::REG_BEAT_STEP,     {16'($urandom), 16'(bstep)});
    cur_bars = (bars == 0) ? 4 : bars;
    n_settings++;
  endtask

  function automatic int pick_step();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 65535;
      2:       return $urandom_range(1, 64);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int pick_bars();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 1;
      2:       return 64;
      default: return $urandom_range(0, 64);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_beat();
    int k;
    k = $urandom_range(0, 2000) * cur_bars;
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $signed(32'($urandom_range(0, 400))) - 200;
      2:       return ($urandom_range(0, 1) == 1) ? -k : k;
      default: return ($urandom_range(0, 1) == 1) ? -k - 1 : k + 1;
    endcase
  endfunction

  task automatic click_train(input int budget, input int max_run);
    int done;
    int run;
    done = 0;
    while (done < budget) begin
      if ($urandom_range(0, 99) < 85) begin
        send_item(click_tb_pkg::CMD_TRIGGER, pick_beat());
        run = $urandom_range(1, max_run);
        repeat (run) send_item(click_tb_pkg::CMD_SAMPLE, $urandom);
        done += run + 1;
      end else begin
        send_item(click_tb_pkg::click_cmd_t'($urandom_range(0, 1)), $urandom);
        done++;
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(click_tb_pkg::CMD_SAMPLE, 0);
    send_item(click_tb_pkg::CMD_TRIGGER, 0);
    repeat (3) send_item(click_tb_pkg::CMD_SAMPLE, 0);
    send_item(click_tb_pkg::CMD_TRIGGER, 1);
    repeat (2) send_item(click_tb_pkg::CMD_SAMPLE, -1);
    send_item(click_tb_pkg::CMD_TRIGGER, -1);
    send_item(click_tb_pkg::CMD_SAMPLE, 32'sh7fff_ffff);
    send_item(click_tb_pkg::CMD_TRIGGER, 32'sh8000_0000);
    send_item(click_tb_pkg::CMD_SAMPLE, 32'sh8000_0000);
    send_item(click_tb_pkg::CMD_TRIGGER, 32'sh7fff_ffff);
    send_item(click_tb_pkg::CMD_SAMPLE, 0);

    settle();
    reg_write(mcs_pkg::REG_ENABLE, 32'hffff_fffe);
    send_item(click_tb_pkg::CMD_TRIGGER, 8);
    repeat (2) send_item(click_tb_pkg::CMD_SAMPLE, 0);

    settle();
    load_settings(1'b1, 0, 65535, 0);
    send_item(click_tb_pkg::CMD_TRIGGER, -4);
    repeat (2) send_item(click_tb_pkg::CMD_SAMPLE, 0);
    send_item(click_tb_pkg::CMD_TRIGGER, 5);
    send_item(click_tb_pkg::CMD_SAMPLE, 0);

    settle();
    load_settings(1'b1, 64, 16384, 65535);
    send_item(click_tb_pkg::CMD_TRIGGER, -64);
    repeat (2) send_item(click_tb_pkg::CMD_SAMPLE, 0);
    send_item(click_tb_pkg::CMD_TRIGGER, 63);
    send_item(click_tb_pkg::CMD_SAMPLE, 0);

    for (int p = 0; p < 8; p++) begin
      settle();
      load_settings($urandom_range(0, 4) != 0, pick_bars(), pick_step(), pick_step());
      click_train(140, 40);
    end

    settle();
    if (pending != 0) begin
      $error("%0d expected samples never arrived", pending);
    end
    $display("Run covered %0d triggers and %0d sample requests over %0d register settings;",
             n_triggers, n_requests, n_settings);
    $display("%0d samples compared, %0d of them nonzero.", compared, audible);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
